// File: design/gaussian_audio_resampler_core_defines.svh
// ---------------------------------------------------------------------------
// Resampler assertion macros
// Clocked assertion helpers shared by the resampler modules; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_AUDIO_RESAMPLER_CORE_DEFINES_SVH
`define GAUSSIAN_AUDIO_RESAMPLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GAR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define GAR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GAR_ASSERT(lbl, cond, msg)
`define GAR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: design/gar_pkg.sv
// ---------------------------------------------------------------------------
// Resampler package
// Shared types, codes and the Gaussian weight generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gar_pkg;

    localparam int unsigned STEP_W  = 24;
    localparam int unsigned DEPTH_W = 2;
    localparam int unsigned MAX_OUT = 64;

    localparam logic [STEP_W-1:0] MIN_STEP      = 24'd4096;
    localparam logic [STEP_W-1:0] RATE_STEP_RST = 24'd65536;

    localparam logic [1:0] REG_RATE_STEP    = 2'd0;
    localparam logic [1:0] REG_SOURCE_DEPTH = 2'd1;
    localparam logic [1:0] REG_TARGET_DEPTH = 2'd2;

    localparam logic [DEPTH_W-1:0] DEPTH_8  = 2'd0;
    localparam logic [DEPTH_W-1:0] DEPTH_16 = 2'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_32 = 2'd2;

    typedef struct packed {
        logic        last;
        logic [31:0] sample;
    } item_t;

    typedef struct packed {
        logic        done;
        logic        last;
        logic [31:0] sample;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOP,
        S_LASTCHK,
        S_FLUSH,
        S_ISTART,
        S_IMUL,
        S_IACC,
        S_IDIVS,
        S_IDIVW,
        S_IDONE,
        S_EMUL,
        S_EPUSH,
        S_FIN
    } back_state_t;

    // exp(-(a/2^pbits)^2) in Q1.15: series for exp(-y/32), then squared five times
    function automatic logic [15:0] weight_q15(input int a, input int pbits);
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] r;
        f = (64'(a) * 64'(a)) << (27 - 2 * pbits);
        s = 64'd1 << 32;
        t = 64'd1 << 32;
        for (int k = 1; k <= 16; k++) begin
            t = ((t * f) >> 32) / 64'(k);
            if ((k % 2) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        for (int q = 0; q < 5; q++) begin
            if (s < (64'd1 << 32)) begin
                s = (s * s) >> 32;
            end
        end
        r = (s + (64'd1 << 16)) >> 17;
        return r[15:0];
    endfunction

endpackage
`default_nettype wire

// File: design/gaussian_audio_resampler_core.sv
// ---------------------------------------------------------------------------
// Gaussian audio resampler core
// Mono PCM sample-rate converter with 5-tap Gaussian interpolation.
// ---------------------------------------------------------------------------
// One raw sample enters per input item; it is decoded to Q1.31 and queued
// (two entries) so the input side can keep accepting while results are
// computed. Each item then enters the history and, for each result it causes,
// goes through a multiply step and an accumulate step per tap, a divide of
// ACC_W = 49 + clog2(TAP_COUNT) quotient bits (52 at the default) at one bit
// per cycle, and two scaling steps; an exact sample position skips the
// multiply-accumulate and the divide. run_last (tlast) closes the results of
// each item, stream_done (tuser) marks the final result of a stream. Up to
// 64 results are given per item.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_audio_resampler_core #(
    parameter int TAP_COUNT  = 5,
    parameter int PHASE_BITS = 6,
    parameter int COUNT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // raw_sample
    input  wire logic        s_tlast,   // stream_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_sample
    output logic             m_tlast,   // run_last
    output logic             m_tuser    // stream_done
);

    logic [gar_pkg::STEP_W-1:0]  rate_step_reg;
    logic [gar_pkg::DEPTH_W-1:0] source_depth_reg;
    logic [gar_pkg::DEPTH_W-1:0] target_depth_reg;
    logic                        q_valid;
    gar_pkg::item_t              q_item;
    logic                        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg    <= gar_pkg::RATE_STEP_RST;
            source_depth_reg <= gar_pkg::DEPTH_16;
            target_depth_reg <= gar_pkg::DEPTH_16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                gar_pkg::REG_RATE_STEP:    rate_step_reg    <= cfg_wdata;
                gar_pkg::REG_SOURCE_DEPTH: source_depth_reg <= cfg_wdata[1:0];
                gar_pkg::REG_TARGET_DEPTH: target_depth_reg <= cfg_wdata[1:0];
                default:
                begin
                end
            endcase
        end
    end

    gar_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_depth (source_depth_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    gar_back #(
        .TAP_COUNT  (TAP_COUNT),
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rate_step    (rate_step_reg),
        .target_depth (target_depth_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule
`default_nettype wire

// File: design/gar_div.sv
// ---------------------------------------------------------------------------
// Resampler divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_audio_resampler_core_defines.svh"
module gar_div #(
    parameter int N = 52,
    parameter int D = 19
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [N-1:0]      quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [D-1:0]     rem_reg, rem_next;
    logic [D-1:0]     dsr_reg, dsr_next;
    logic [N-1:0]     quo_reg, quo_next;
    logic [D:0]       rem_sh;
    logic [D:0]       rem_sub;
    logic             ge;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[N-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        ge      = rem_sh >= {1'b0, dsr_reg};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(N);
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
            quo_next = {quo_reg[N-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    `GAR_ASSERT_IMPL(a_div_no_restart, start, !busy_reg, "divider started while busy")

endmodule
`default_nettype wire

// File: design/gar_front.sv
// ---------------------------------------------------------------------------
// Resampler front end
// Accepts raw items, decodes them to Q1.31 and queues them for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_audio_resampler_core_defines.svh"
module gar_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [gar_pkg::DEPTH_W-1:0]      source_depth,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,   // raw_sample
    input  wire logic                             s_tlast,   // stream_end
    output logic                                  q_valid,
    output gar_pkg::item_t                        q_item,
    input  wire logic                             q_pop
);

    gar_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic [31:0]    decoded;

    always_comb
    begin
        case (source_depth)
            gar_pkg::DEPTH_8:  decoded = {~s_tdata[7], s_tdata[6:0], 24'd0};
            gar_pkg::DEPTH_16: decoded = {s_tdata[15:0], 16'd0};
            default:           decoded = s_tdata;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{last: s_tlast, sample: decoded};
        end
    end

    `GAR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "queue popped while empty")
    `GAR_ASSERT_IMPL(a_push_visible, push && !q_pop, ##1 q_valid, "pushed item not queued")

endmodule
`default_nettype wire

// File: design/gar_back.sv
// ---------------------------------------------------------------------------
// Resampler back end
// History, position tracking, Gaussian interpolation, scaling and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_audio_resampler_core_defines.svh"
module gar_back #(
    parameter int TAP_COUNT  = 5,
    parameter int PHASE_BITS = 6,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [gar_pkg::STEP_W-1:0]  rate_step,
    input  wire logic [gar_pkg::DEPTH_W-1:0] target_depth,
    input  wire logic                        q_valid,
    input  wire gar_pkg::item_t              q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,   // out_sample
    output logic                             m_tlast,   // run_last
    output logic                             m_tuser    // stream_done
);

    localparam int CW       = COUNT_BITS;
    localparam int POS_W    = CW + 16;
    localparam int TAP_LO   = TAP_COUNT / 2;
    localparam int TAP_HI   = TAP_COUNT - 1 - TAP_LO;
    localparam int TW       = $clog2(TAP_COUNT);
    localparam int WT_DEPTH = (TAP_LO + 1) << PHASE_BITS;
    localparam int WI       = $clog2(WT_DEPTH);
    localparam int AW       = WI + 2;
    localparam int ACC_W    = 32 + 16 + $clog2(TAP_COUNT) + 1;
    localparam int WS_W     = 16 + $clog2(TAP_COUNT);
    localparam int NW       = $clog2(gar_pkg::MAX_OUT + 1);
    localparam int SW       = gar_pkg::STEP_W;
    localparam int IW       = CW + 2;

    logic [15:0] wtab [WT_DEPTH];
    for (genvar g = 0; g < WT_DEPTH; g++)
    begin : g_wtab
        localparam logic [15:0] WV = gar_pkg::weight_q15(g, PHASE_BITS);
        assign wtab[g] = WV;
    end

    gar_pkg::back_state_t state_reg, state_next, eret_reg, eret_next;
    logic signed [31:0]   hist_reg [TAP_COUNT];
    logic signed [31:0]   hist_next [TAP_COUNT];
    logic [CW-1:0]        count_reg, count_next;
    logic [POS_W-1:0]     next_pos_reg, next_pos_next;
    logic [POS_W-1:0]     held_pos_reg, held_pos_next;
    logic [POS_W-1:0]     ipos_reg, ipos_next;
    logic                 held_valid_reg, held_valid_next;
    logic signed [31:0]   held_value_reg, held_value_next;
    logic                 last_reg, last_next;
    logic [NW-1:0]        n_reg, n_next;
    logic                 iflush_reg, iflush_next;
    logic [TW-1:0]        tap_reg, tap_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [WS_W-1:0]      wsum_reg, wsum_next;
    logic signed [48:0]   prod_reg, prod_next;
    logic                 tap_ok_reg, tap_ok_next;
    logic [15:0]          w_reg, w_next;
    logic signed [31:0]   ires_reg, ires_next;
    logic signed [31:0]   emit_val_reg, emit_val_next;
    logic signed [63:0]   scale_reg, scale_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [31:0]          pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    gar_pkg::result_t     out_reg, out_next;
    logic                 out_load;

    logic [SW-1:0]        eff_step;
    logic                 held_within;
    logic                 next_within;
    logic                 lookahead_stop;
    logic                 n_full;
    logic                 slot_free;
    logic                 frac_zero;
    logic                 tap_last;
    logic                 wsum_zero;
    logic [CW-1:0]        i_idx;
    logic [PHASE_BITS-1:0] phase;
    logic [TW-1:0]        f_off;
    logic signed [IW-1:0] idx;
    logic signed [IW-1:0] diff;
    logic [IW-1:0]        hsel;
    logic                 present;
    logic signed [31:0]   fetched;
    logic signed [AW-1:0] d_s;
    logic [AW-1:0]        a_u;
    logic [15:0]          w_cur;
    logic signed [31:0]   mult_m;
    logic signed [63:0]   scaled_r;
    logic [31:0]          scaled;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [ACC_W-1:0]     div_dividend;
    logic [ACC_W-1:0]     div_quo;
    logic signed [31:0]   div_res;

    // true if pos + step <= cnt * 65536
    function automatic logic within_f(input logic [POS_W-1:0] pos,
                                      input logic [SW-1:0] step,
                                      input logic [CW-1:0] cnt);
        logic [SW:0] s;
        logic [CW:0] whole;
        s     = (SW+1)'(pos[15:0]) + (SW+1)'(step);
        whole = (CW+1)'(pos[POS_W-1:16]) + (CW+1)'(s[SW:16]);
        return (whole < (CW+1)'(cnt)) || ((whole == (CW+1)'(cnt)) && (s[15:0] == 16'd0));
    endfunction

    always_comb
    begin
        eff_step       = (rate_step < gar_pkg::MIN_STEP) ? gar_pkg::MIN_STEP : rate_step;
        held_within    = within_f(held_pos_reg, eff_step, count_reg);
        next_within    = within_f(next_pos_reg, eff_step, count_reg);
        lookahead_stop = ((CW+1)'(next_pos_reg[POS_W-1:16]) + (CW+1)'(TAP_HI))
                         >= (CW+1)'(count_reg);
        n_full         = (n_reg == NW'(gar_pkg::MAX_OUT));
        slot_free      = !out_valid_reg || m_tready;
        frac_zero      = (ipos_reg[15:0] == 16'd0);
        tap_last       = (tap_reg == TW'(TAP_COUNT - 1));
        wsum_zero      = (wsum_reg == '0);
    end

    // tap fetch and weight lookup
    always_comb
    begin
        i_idx   = ipos_reg[POS_W-1:16];
        phase   = ipos_reg[15 -: PHASE_BITS];
        f_off   = (state_reg == gar_pkg::S_ISTART) ? TW'(TAP_LO) : tap_reg;
        idx     = $signed(IW'(i_idx)) + $signed(IW'(f_off)) - $signed(IW'(TAP_LO));
        diff    = $signed(IW'(count_reg)) - idx;
        present = !idx[IW-1] && !diff[IW-1] && (diff != '0)
                  && (diff <= $signed(IW'(TAP_COUNT)));
        hsel    = IW'(TAP_COUNT) - diff;
        fetched = present ? hist_reg[hsel[TW-1:0]] : 32'sd0;
        d_s     = $signed(AW'(tap_reg) << PHASE_BITS) - $signed(AW'(TAP_LO) << PHASE_BITS)
                  - $signed(AW'(phase));
        a_u     = d_s[AW-1] ? AW'(-d_s) : AW'(d_s);
        w_cur   = wtab[a_u[WI-1:0]];
    end

    always_comb
    begin
        case (target_depth)
            gar_pkg::DEPTH_8:  mult_m = 32'sd127;
            gar_pkg::DEPTH_16: mult_m = 32'sd32767;
            default:           mult_m = 32'sd2147483647;
        endcase
        scaled_r = (scale_reg + (scale_reg[63] ? 64'sd2147483647 : 64'sd0)) >>> 31;
        scaled   = scaled_r[31:0];
    end

    assign div_dividend = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_start    = (state_reg == gar_pkg::S_IDIVS) && !wsum_zero;

    always_comb
    begin
        if (!acc_reg[ACC_W-1])
        begin
            div_res = (div_quo > ACC_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        end
        else
        begin
            div_res = (div_quo > ACC_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                         : $signed(-div_quo[31:0]);
        end
    end

    gar_div #(
        .N(ACC_W),
        .D(WS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (wsum_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q_pop = (state_reg == gar_pkg::S_IDLE) && q_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gar_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = gar_pkg::S_LOOP;
                end
            end
            gar_pkg::S_LOOP:
            begin
                if (n_full)
                begin
                    state_next = gar_pkg::S_LASTCHK;
                end
                else if (held_valid_reg)
                begin
                    state_next = held_within ? gar_pkg::S_EMUL : gar_pkg::S_LASTCHK;
                end
                else
                begin
                    state_next = lookahead_stop ? gar_pkg::S_LASTCHK : gar_pkg::S_ISTART;
                end
            end
            gar_pkg::S_LASTCHK:
            begin
                if (!last_reg)
                begin
                    state_next = gar_pkg::S_FIN;
                end
                else if (held_valid_reg && !n_full && held_within)
                begin
                    state_next = gar_pkg::S_EMUL;
                end
                else
                begin
                    state_next = gar_pkg::S_FLUSH;
                end
            end
            gar_pkg::S_FLUSH:
            begin
                state_next = (!held_valid_reg && !n_full && next_within) ? gar_pkg::S_ISTART
                                                                        : gar_pkg::S_FIN;
            end
            gar_pkg::S_ISTART:
            begin
                state_next = frac_zero ? gar_pkg::S_IDONE : gar_pkg::S_IMUL;
            end
            gar_pkg::S_IMUL:
            begin
                state_next = gar_pkg::S_IACC;
            end
            gar_pkg::S_IACC:
            begin
                state_next = tap_last ? gar_pkg::S_IDIVS : gar_pkg::S_IMUL;
            end
            gar_pkg::S_IDIVS:
            begin
                state_next = wsum_zero ? gar_pkg::S_IDONE : gar_pkg::S_IDIVW;
            end
            gar_pkg::S_IDIVW:
            begin
                if (div_done)
                begin
                    state_next = gar_pkg::S_IDONE;
                end
            end
            gar_pkg::S_IDONE:
            begin
                state_next = iflush_reg ? gar_pkg::S_EMUL : gar_pkg::S_LOOP;
            end
            gar_pkg::S_EMUL:
            begin
                state_next = gar_pkg::S_EPUSH;
            end
            gar_pkg::S_EPUSH:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    state_next = eret_reg;
                end
            end
            gar_pkg::S_FIN:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    state_next = gar_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gar_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        eret_next       = eret_reg;
        hist_next       = hist_reg;
        count_next      = count_reg;
        next_pos_next   = next_pos_reg;
        held_pos_next   = held_pos_reg;
        ipos_next       = ipos_reg;
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        iflush_next     = iflush_reg;
        tap_next        = tap_reg;
        acc_next        = acc_reg;
        wsum_next       = wsum_reg;
        prod_next       = prod_reg;
        tap_ok_next     = tap_ok_reg;
        w_next          = w_reg;
        ires_next       = ires_reg;
        emit_val_next   = emit_val_reg;
        scale_next      = scale_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_next        = out_reg;

        unique case (state_reg)
            gar_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    for (int j = 0; j < TAP_COUNT - 1; j++)
                    begin
                        hist_next[j] = hist_reg[j+1];
                    end
                    hist_next[TAP_COUNT-1] = $signed(q_item.sample);
                    if (count_reg != {CW{1'b1}})
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    last_next = q_item.last;
                    n_next    = '0;
                end
            end
            gar_pkg::S_LOOP:
            begin
                if (!n_full)
                begin
                    if (held_valid_reg)
                    begin
                        if (held_within)
                        begin
                            emit_val_next   = held_value_reg;
                            held_valid_next = 1'b0;
                            n_next          = n_reg + NW'(1);
                            eret_next       = gar_pkg::S_LOOP;
                        end
                    end
                    else if (!lookahead_stop)
                    begin
                        ipos_next     = next_pos_reg;
                        next_pos_next = next_pos_reg + POS_W'(eff_step);
                        iflush_next   = 1'b0;
                    end
                end
            end
            gar_pkg::S_LASTCHK:
            begin
                if (last_reg && held_valid_reg && !n_full && held_within)
                begin
                    emit_val_next   = held_value_reg;
                    held_valid_next = 1'b0;
                    n_next          = n_reg + NW'(1);
                    eret_next       = gar_pkg::S_FLUSH;
                end
            end
            gar_pkg::S_FLUSH:
            begin
                if (!held_valid_reg && !n_full && next_within)
                begin
                    ipos_next     = next_pos_reg;
                    next_pos_next = next_pos_reg + POS_W'(eff_step);
                    iflush_next   = 1'b1;
                end
            end
            gar_pkg::S_ISTART:
            begin
                ires_next = fetched;
                tap_next  = '0;
                acc_next  = '0;
                wsum_next = '0;
            end
            gar_pkg::S_IMUL:
            begin
                prod_next   = fetched * $signed({1'b0, w_cur});
                tap_ok_next = present;
                w_next      = w_cur;
            end
            gar_pkg::S_IACC:
            begin
                if (tap_ok_reg)
                begin
                    acc_next  = acc_reg + ACC_W'(prod_reg);
                    wsum_next = wsum_reg + WS_W'(w_reg);
                end
                tap_next = tap_reg + TW'(1);
            end
            gar_pkg::S_IDIVS:
            begin
                if (wsum_zero)
                begin
                    ires_next = 32'sd0;
                end
            end
            gar_pkg::S_IDIVW:
            begin
                if (div_done)
                begin
                    ires_next = div_res;
                end
            end
            gar_pkg::S_IDONE:
            begin
                if (iflush_reg)
                begin
                    emit_val_next = ires_reg;
                    n_next        = n_reg + NW'(1);
                    eret_next     = gar_pkg::S_FLUSH;
                end
                else
                begin
                    held_value_next = ires_reg;
                    held_pos_next   = ipos_reg;
                    held_valid_next = 1'b1;
                end
            end
            gar_pkg::S_EMUL:
            begin
                scale_next = emit_val_reg * mult_m;
            end
            gar_pkg::S_EPUSH:
            begin
                if (!pend_valid_reg)
                begin
                    pend_next       = scaled;
                    pend_valid_next = 1'b1;
                end
                else if (slot_free)
                begin
                    out_load  = 1'b1;
                    out_next  = '{done: 1'b0, last: 1'b0, sample: pend_reg};
                    pend_next = scaled;
                end
            end
            gar_pkg::S_FIN:
            begin
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load        = 1'b1;
                        out_next        = '{done: last_reg, last: 1'b1, sample: pend_reg};
                        pend_valid_next = 1'b0;
                    end
                    if (last_reg)
                    begin
                        for (int j = 0; j < TAP_COUNT; j++)
                        begin
                            hist_next[j] = 32'sd0;
                        end
                        count_next      = '0;
                        next_pos_next   = '0;
                        held_valid_next = 1'b0;
                        held_pos_next   = '0;
                        held_value_next = 32'sd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gar_pkg::S_IDLE;
            eret_reg       <= gar_pkg::S_IDLE;
            for (int j = 0; j < TAP_COUNT; j++)
            begin
                hist_reg[j] <= 32'sd0;
            end
            count_reg      <= '0;
            next_pos_reg   <= '0;
            held_pos_reg   <= '0;
            held_valid_reg <= 1'b0;
            held_value_reg <= 32'sd0;
            last_reg       <= 1'b0;
            n_reg          <= '0;
            iflush_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            eret_reg       <= eret_next;
            hist_reg       <= hist_next;
            count_reg      <= count_next;
            next_pos_reg   <= next_pos_next;
            held_pos_reg   <= held_pos_next;
            held_valid_reg <= held_valid_next;
            held_value_reg <= held_value_next;
            last_reg       <= last_next;
            n_reg          <= n_next;
            iflush_reg     <= iflush_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ipos_reg     <= ipos_next;
        tap_reg      <= tap_next;
        acc_reg      <= acc_next;
        wsum_reg     <= wsum_next;
        prod_reg     <= prod_next;
        tap_ok_reg   <= tap_ok_next;
        w_reg        <= w_next;
        ires_reg     <= ires_next;
        emit_val_reg <= emit_val_next;
        scale_reg    <= scale_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sample;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.done;

    `GAR_ASSERT(a_no_overwrite, !(out_load && out_valid_reg && !m_tready), "output overwritten")
    `GAR_ASSERT(a_result_cap, n_reg <= NW'(gar_pkg::MAX_OUT), "result count above cap")
    `GAR_ASSERT_IMPL(a_idle_drained, state_reg == gar_pkg::S_IDLE, !pend_valid_reg, "result left pending")

endmodule
`default_nettype wire
